### rtl/core/ntc_pkg.sv
package ntc_pkg;

  localparam int RupW  = 20;
  localparam int CoefW = 48;
  localparam int IdxW  = 8;
  localparam int TempW = 16;
  localparam int StatW = 2;
  // widest divider: 16-bit converter, 20-bit resistor, Q.16
  localparam int DenW  = 16;
  localparam int NumW  = 52;
  localparam int QDepth = 4;

  localparam logic [StatW-1:0] StatOk   = 2'd0;
  localparam logic [StatW-1:0] StatRail = 2'd1;
  localparam logic [StatW-1:0] StatSat  = 2'd2;

  localparam logic [IdxW-1:0] RegRup   = 8'd0;
  localparam logic [IdxW-1:0] RegCoefA = 8'd1;
  localparam logic [IdxW-1:0] RegCoefB = 8'd2;
  localparam logic [IdxW-1:0] RegCoefC = 8'd3;

  localparam logic [RupW-1:0]  RupReset   = 20'd10000;
  localparam logic [CoefW-1:0] CoefAReset = 48'd284078485694;
  localparam logic [CoefW-1:0] CoefBReset = 48'd66946175000;
  localparam logic [CoefW-1:0] CoefCReset = 48'd56835502;

  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic signed [57:0] KelvinCenti = 58'sd27315;
  localparam logic [54:0] RecipNum = 55'd100 << 48;

  typedef struct packed {
    logic [RupW-1:0]  rup;
    logic [CoefW-1:0] coef_a;
    logic [CoefW-1:0] coef_b;
    logic [CoefW-1:0] coef_c;
  } cfg_t;

  typedef struct packed {
    logic            rail;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } item_t;

  typedef struct packed {
    logic vld;
    logic full;
  } q_stat_t;

endpackage

### rtl/core/ntc_if.sv
interface ntc_in_if #(parameter int ADC_BITS = 12);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;
  modport source (output valid, adc_code, input ready);
  modport sink (input valid, adc_code, output ready);
endinterface

interface ntc_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] temperature_centi;
  logic [1:0]        status;
  modport source (output valid, temperature_centi, status, input ready);
  modport sink (input valid, temperature_centi, status, output ready);
endinterface

interface ntc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/ntc_front.sv
module ntc_front #(
  parameter int ADC_BITS = 12
) (
  input  logic                         in_valid_i,
  input  logic [ADC_BITS-1:0]          adc_code_i,
  input  logic [ntc_pkg::RupW-1:0]     rup_i,
  input  ntc_pkg::q_stat_t             q_stat_i,
  output logic                         in_ready_o,
  output logic                         push_o,
  output ntc_pkg::item_t               item_o
);

  localparam logic [ntc_pkg::DenW-1:0] Full =
    ntc_pkg::DenW'((32'd1 << ADC_BITS) - 32'd1);

  logic [ntc_pkg::DenW-1:0] code;
  logic [35:0]              prod;

  always_comb begin
    code = ntc_pkg::DenW'(adc_code_i) & Full;
    prod = 36'(rup_i) * 36'(code);
    // rail codes and a zero resistor carry no resistance
    item_o.rail = (code == '0) || (code == Full) || (rup_i == '0);
    item_o.num  = {prod, 16'd0};
    item_o.den  = Full - code;
  end

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

endmodule

### rtl/core/ntc_queue.sv
module ntc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ntc_pkg::item_t   item_i,
  input  logic             pop_i,
  output ntc_pkg::item_t   item_o,
  output ntc_pkg::q_stat_t stat_o
);

  localparam int PtrW = $clog2(ntc_pkg::QDepth);

  ntc_pkg::item_t mem_q [ntc_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign stat_o.vld  = (cnt_q != '0);
  assign stat_o.full = (cnt_q == (PtrW+1)'(ntc_pkg::QDepth));
  assign do_push     = push_i && !stat_o.full;
  assign do_pop      = pop_i && stat_o.vld;
  assign item_o      = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

### rtl/core/ntc_back.sv
module ntc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ntc_pkg::cfg_t      cfg_i,
  input  logic               q_vld_i,
  input  ntc_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] temp_o,
  output logic [1:0]         status_o
);

  localparam int D1Stg = 13;
  localparam int D1Per = ntc_pkg::NumW / D1Stg;
  localparam int NStg  = 6;
  localparam int LStg  = 24;
  localparam int QStg  = 55;

  logic adv;
  logic out_vld_q;

  assign adv         = !out_vld_q || out_ready_i;
  assign q_pop_o     = adv && q_vld_i;
  assign out_valid_o = out_vld_q;

  // resistance divider, four quotient bits per stage
  logic        d1_vld  [D1Stg+1];
  logic        d1_rail [D1Stg+1];
  logic [15:0] d1_rem  [D1Stg+1];
  logic [51:0] d1_dq   [D1Stg+1];
  logic [15:0] d1_den  [D1Stg+1];

  assign d1_vld[0]  = q_vld_i;
  assign d1_rail[0] = q_item_i.rail;
  assign d1_rem[0]  = '0;
  assign d1_dq[0]   = q_item_i.num;
  assign d1_den[0]  = q_item_i.den;

  function automatic logic [67:0] div1_step(logic [15:0] rem, logic [51:0] dq,
                                            logic [15:0] den);
    logic [16:0] t;
    logic [15:0] r;
    logic [51:0] d;
    r = rem;
    d = dq;
    for (int i = 0; i < D1Per; i++) begin
      t = {r, d[51]};
      if (t >= {1'b0, den}) begin
        r = 16'(t - {1'b0, den});
        d = {d[50:0], 1'b1};
      end else begin
        r = t[15:0];
        d = {d[50:0], 1'b0};
      end
    end
    return {r, d};
  endfunction

  for (genvar g = 0; g < D1Stg; g++) begin : g_d1
    logic [67:0] nxt;
    assign nxt = div1_step(d1_rem[g], d1_dq[g], d1_den[g]);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d1_vld[g+1] <= 1'b0;
      else if (adv) d1_vld[g+1] <= d1_vld[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_rail[g+1] <= d1_rail[g];
        d1_rem[g+1]  <= nxt[67:52];
        d1_dq[g+1]   <= nxt[51:0];
        d1_den[g+1]  <= d1_den[g];
      end
    end
  end

  // normalize: binary leading-one search
  logic        n_vld  [NStg+1];
  logic        n_rail [NStg+1];
  logic [51:0] n_v    [NStg+1];
  logic [5:0]  n_sh   [NStg+1];

  assign n_vld[0]  = d1_vld[D1Stg];
  assign n_rail[0] = d1_rail[D1Stg];
  assign n_v[0]    = d1_dq[D1Stg];
  assign n_sh[0]   = '0;

  for (genvar g = 0; g < NStg; g++) begin : g_n
    localparam int Sh = 32 >> g;
    logic hit;
    assign hit = (n_v[g][51 -: Sh] == '0);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) n_vld[g+1] <= 1'b0;
      else if (adv) n_vld[g+1] <= n_vld[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        n_rail[g+1] <= n_rail[g];
        n_v[g+1]    <= hit ? (n_v[g] << Sh) : n_v[g];
        n_sh[g+1]   <= hit ? (n_sh[g] + 6'(Sh)) : n_sh[g];
      end
    end
  end

  // log2 fraction, one squaring per stage
  logic        l_vld  [LStg+1];
  logic        l_rail [LStg+1];
  logic [30:0] l_m    [LStg+1];
  logic [23:0] l_frac [LStg+1];
  logic [5:0]  l_sh   [LStg+1];

  assign l_vld[0]  = n_vld[NStg];
  assign l_rail[0] = n_rail[NStg];
  assign l_m[0]    = n_v[NStg][51:21];
  assign l_frac[0] = '0;
  assign l_sh[0]   = n_sh[NStg];

  for (genvar g = 0; g < LStg; g++) begin : g_l
    logic [61:0] sq;
    logic [31:0] m2;
    assign sq = 62'(l_m[g]) * 62'(l_m[g]);
    assign m2 = sq[61:30];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) l_vld[g+1] <= 1'b0;
      else if (adv) l_vld[g+1] <= l_vld[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        l_rail[g+1] <= l_rail[g];
        l_m[g+1]    <= m2[31] ? m2[31:1] : m2[30:0];
        l_frac[g+1] <= {l_frac[g][22:0], m2[31]};
        l_sh[g+1]   <= l_sh[g];
      end
    end
  end

  // polynomial, sign and magnitude
  logic [47:0] b_mag, c_mag;
  assign b_mag = cfg_i.coef_b[47] ? (~cfg_i.coef_b + 48'd1) : cfg_i.coef_b;
  assign c_mag = cfg_i.coef_c[47] ? (~cfg_i.coef_c + 48'd1) : cfg_i.coef_c;

  logic [8:1]  a_vld;
  logic [8:1]  a_rail;
  logic [29:0] a1_xm, a2_xm, a3_xm, a4_xm;
  logic        a1_xn, a2_xn, a3_xn, a4_xn, a5_xn;
  logic [33:0] a2_x2;
  logic [37:0] a3_x3, a4_x3;
  logic [53:0] a4_pb0, a5_pb0, a5_pb1, a6_bx;
  logic [61:0] a4_pc0, a5_pc0, a5_pc1, a6_cx;
  logic        a6_bn, a6_cn;
  logic signed [63:0] a7_s;
  logic        a8_zero, a8_neg;
  logic [62:0] a8_us;

  logic signed [7:0]  l_int;
  logic signed [31:0] l_val;
  logic [30:0]        l_mag;
  logic [61:0]        x_prod;
  logic [59:0]        x2_prod;
  logic [63:0]        x3_prod;
  logic signed [63:0] s_a, s_b, s_c;

  always_comb begin
    l_int   = 8'sd35 - $signed({2'b0, l_sh[LStg]});
    l_val   = $signed({l_int, 24'd0}) + $signed({8'd0, l_frac[LStg]});
    l_mag   = l_val[31] ? 31'(-l_val) : l_val[30:0];
    x_prod  = 62'(l_mag) * 62'(ntc_pkg::Ln2Q32);
    x2_prod = 60'(a1_xm) * 60'(a1_xm);
    x3_prod = 64'(a2_x2) * 64'(a2_xm);
    s_a     = {{16{cfg_i.coef_a[47]}}, cfg_i.coef_a};
    s_b     = a6_bn ? -$signed({10'd0, a6_bx}) : $signed({10'd0, a6_bx});
    s_c     = a6_cn ? -$signed({2'd0, a6_cx}) : $signed({2'd0, a6_cx});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld <= '0;
    else if (adv) a_vld <= {a_vld[7:1], l_vld[LStg]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_rail <= {a_rail[7:1], l_rail[LStg]};
      a1_xm  <= x_prod[61:32];
      a1_xn  <= l_val[31];
      a2_x2  <= x2_prod[57:24];
      a2_xm  <= a1_xm;
      a2_xn  <= a1_xn;
      a3_x3  <= x3_prod[61:24];
      a3_xm  <= a2_xm;
      a3_xn  <= a2_xn;
      a4_pb0 <= 54'(b_mag[23:0]) * 54'(a3_xm);
      a4_pc0 <= 62'(c_mag[23:0]) * 62'(a3_x3);
      a4_xm  <= a3_xm;
      a4_x3  <= a3_x3;
      a4_xn  <= a3_xn;
      a5_pb1 <= 54'(b_mag[47:24]) * 54'(a4_xm);
      a5_pc1 <= 62'(c_mag[47:24]) * 62'(a4_x3);
      a5_pb0 <= a4_pb0;
      a5_pc0 <= a4_pc0;
      a5_xn  <= a4_xn;
      a6_bx  <= a5_pb1 + 54'(a5_pb0[53:24]);
      a6_cx  <= a5_pc1 + 62'(a5_pc0[61:24]);
      a6_bn  <= cfg_i.coef_b[47] ^ a5_xn;
      a6_cn  <= cfg_i.coef_c[47] ^ a5_xn;
      a7_s   <= s_a + s_b + s_c;
      a8_zero <= (a7_s == '0);
      a8_neg  <= a7_s[63];
      a8_us   <= a7_s[63] ? 63'(-a7_s) : a7_s[62:0];
    end
  end

  // reciprocal divider, one quotient bit per stage
  logic        q_vld  [QStg+1];
  logic        q_rail [QStg+1];
  logic        q_zero [QStg+1];
  logic        q_neg  [QStg+1];
  logic [62:0] q_us   [QStg+1];
  logic [62:0] q_rem  [QStg+1];
  logic [54:0] q_dq   [QStg+1];

  assign q_vld[0]  = a_vld[8];
  assign q_rail[0] = a_rail[8];
  assign q_zero[0] = a8_zero;
  assign q_neg[0]  = a8_neg;
  assign q_us[0]   = a8_us;
  assign q_rem[0]  = '0;
  assign q_dq[0]   = ntc_pkg::RecipNum;

  for (genvar g = 0; g < QStg; g++) begin : g_q
    logic [63:0] t;
    logic        ge;
    assign t  = {q_rem[g], q_dq[g][54]};
    assign ge = (t >= {1'b0, q_us[g]});
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) q_vld[g+1] <= 1'b0;
      else if (adv) q_vld[g+1] <= q_vld[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        q_rail[g+1] <= q_rail[g];
        q_zero[g+1] <= q_zero[g];
        q_neg[g+1]  <= q_neg[g];
        q_us[g+1]   <= q_us[g];
        q_rem[g+1]  <= ge ? 63'(t - {1'b0, q_us[g]}) : t[62:0];
        q_dq[g+1]   <= {q_dq[g][53:0], ge};
      end
    end
  end

  // round half away from zero, then offset and clamp
  logic        r_vld_q, r_rail_q, r_zero_q, r_neg_q;
  logic [55:0] r_q_q;
  logic        round_up;
  logic signed [57:0] q_sgn, t_val;
  logic signed [15:0] temp_d;
  logic [1:0]         stat_d;
  logic signed [15:0] temp_q;
  logic [1:0]         stat_q;

  assign round_up = ({q_rem[QStg], 1'b0} >= {1'b0, q_us[QStg]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      r_vld_q   <= q_vld[QStg];
      out_vld_q <= r_vld_q;
    end
  end

  always_comb begin
    q_sgn = r_neg_q ? -$signed({2'b0, r_q_q}) : $signed({2'b0, r_q_q});
    t_val = q_sgn - ntc_pkg::KelvinCenti;
    priority if (r_rail_q) begin
      temp_d = '0;
      stat_d = ntc_pkg::StatRail;
    end else if (r_zero_q) begin
      temp_d = 16'sh7fff;
      stat_d = ntc_pkg::StatSat;
    end else if (t_val > 58'sd32767) begin
      temp_d = 16'sh7fff;
      stat_d = ntc_pkg::StatSat;
    end else if (t_val < -58'sd32768) begin
      temp_d = 16'sh8000;
      stat_d = ntc_pkg::StatSat;
    end else begin
      temp_d = t_val[15:0];
      stat_d = ntc_pkg::StatOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_rail_q <= q_rail[QStg];
      r_zero_q <= q_zero[QStg];
      r_neg_q  <= q_neg[QStg];
      r_q_q    <= 56'(q_dq[QStg]) + 56'(round_up);
      temp_q   <= temp_d;
      stat_q   <= stat_d;
    end
  end

  assign temp_o   = temp_q;
  assign status_o = stat_q;

endmodule

### rtl/core/ntc_adc_to_temperature_unit.sv
// NTC thermistor converter: ADC code in, temperature in hundredths of a
// degree Celsius out.
// Channels: in_i carries one adc_code per item, out_o one temperature_centi
// and status per item, cfg_i writes the divider resistor (index 0) and the
// Steinhart-Hart coefficients A, B, C (indexes 1..3); other indexes drop.
// cfg_i is always ready; write it only while no item is in flight.
// Throughput: one item per clock while out_o is taken.
// The pipeline is a 13-stage resistance divider (4 bits a stage), 6
// normalize stages, 24 log squaring stages, 8 polynomial stages, a 55-stage
// reciprocal divider (1 bit a stage), a rounding stage and the output
// register.
// The front takes items into a 4-entry queue; in_i.ready drops only when
// that queue is full. When out_o stalls, the whole back pipeline holds and
// the queue absorbs up to four further items.
// Reset clears the pipeline and queue and loads the default resistor and
// coefficients; no clearing pass is needed.
module ntc_adc_to_temperature_unit #(
  parameter int ADC_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntc_in_if.sink     in_i,
  ntc_out_if.source  out_o,
  ntc_cfg_if.sink    cfg_i
);

  ntc_pkg::cfg_t    cfg_q;
  ntc_pkg::item_t   f_item, q_item;
  ntc_pkg::q_stat_t q_stat;
  logic             push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rup    <= ntc_pkg::RupReset;
      cfg_q.coef_a <= ntc_pkg::CoefAReset;
      cfg_q.coef_b <= ntc_pkg::CoefBReset;
      cfg_q.coef_c <= ntc_pkg::CoefCReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ntc_pkg::RegRup:   cfg_q.rup    <= cfg_i.data[ntc_pkg::RupW-1:0];
        ntc_pkg::RegCoefA: cfg_q.coef_a <= cfg_i.data;
        ntc_pkg::RegCoefB: cfg_q.coef_b <= cfg_i.data;
        ntc_pkg::RegCoefC: cfg_q.coef_c <= cfg_i.data;
        default: ;
      endcase
    end
  end

  ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .in_valid_i (in_i.valid),
    .adc_code_i (in_i.adc_code),
    .rup_i      (cfg_q.rup),
    .q_stat_i   (q_stat),
    .in_ready_o (in_i.ready),
    .push_o     (push),
    .item_o     (f_item)
  );

  ntc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  ntc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_vld_i     (q_stat.vld),
    .q_item_i    (q_item),
    .q_pop_o     (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .temp_o      (out_o.temperature_centi),
    .status_o    (out_o.status)
  );

endmodule

### rtl/core/ntc_checker.sv
module ntc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] temp_i,
  input logic [1:0]  status_i,
  input logic        cfg_ready_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(temp_i) && $stable(status_i))
    else $error("result changed under stall");

  a_rail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ntc_pkg::StatRail |-> temp_i == 16'd0)
    else $error("rail fault with nonzero temperature");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ntc_pkg::StatSat |->
      temp_i == 16'h7fff || temp_i == 16'h8000)
    else $error("saturated result not at a bound");

  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i != 2'd3)
    else $error("undefined status");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind ntc_adc_to_temperature_unit ntc_checker u_ntc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .temp_i      (out_o.temperature_centi),
  .status_i    (out_o.status),
  .cfg_ready_i (cfg_i.ready)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  ntc_in_if  #(.ADC_BITS(12)) in_if ();
  ntc_out_if                  out_if ();
  ntc_cfg_if                  cfg_if ();

  ntc_adc_to_temperature_unit #(.ADC_BITS(12)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  typedef struct packed {
    logic signed [15:0] temp;
    logic [1:0]         stat;
  } reading_t;

  localparam int Latency = 108;
  localparam logic [63:0] ProdCap = 64'd1 << 61;

  logic [19:0]        rup_ohms;
  logic signed [47:0] k_a, k_b, k_c;

  reading_t pending_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_sat = 0;
  int n_rail = 0;
  bit hold_long = 0;
  bit drain_on = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.adc_code = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  // trunc(a*b / 2^sh), magnitude capped at 2^61
  function automatic longint scaled_mul(longint a, longint b, int sh);
    logic [127:0] ua, ub, prod;
    logic [63:0]  mag;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ua * ub) >> sh;
    mag = (prod > 128'(ProdCap)) ? ProdCap : prod[63:0];
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint ln_fixed(logic [63:0] r);
    int p;
    logic [63:0] m;
    longint frac;
    p = 63;
    frac = 0;
    while (p > 0 && r[p] == 1'b0) p--;
    m = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
    for (int i = 1; i <= 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (longint'(1) << (24 - i));
      end
    end
    return scaled_mul(longint'(p - 16) * (longint'(1) << 24) + frac,
                      longint'(ntc_pkg::Ln2Q32), 32);
  endfunction

  function automatic reading_t convert_code(logic [11:0] code);
    reading_t res;
    logic [63:0] r, us, q, num;
    longint x, x2, x3, s, t;
    res.temp = '0;
    res.stat = ntc_pkg::StatRail;
    if (code == 12'd0 || code == 12'hFFF) return res;
    r = ((64'(rup_ohms) * code) << 16) / (64'd4095 - code);
    if (r == 0) return res;
    x = ln_fixed(r);
    x2 = scaled_mul(x, x, 24);
    x3 = scaled_mul(x2, x, 24);
    s = longint'(k_a) + scaled_mul(k_b, x, 24) + scaled_mul(k_c, x3, 24);
    res.stat = ntc_pkg::StatOk;
    if (s == 0) begin
      t = 32767;
      res.stat = ntc_pkg::StatSat;
    end else begin
      num = 64'd100 << 48;
      us = (s < 0) ? 64'(-s) : 64'(s);
      q = num / us;
      if ((num % us) * 2 >= us) q++;
      t = ((s < 0) ? -longint'(q) : longint'(q)) - 27315;
      if (t > 32767) begin
        t = 32767;
        res.stat = ntc_pkg::StatSat;
      end else if (t < -32768) begin
        t = -32768;
        res.stat = ntc_pkg::StatSat;
      end
    end
    res.temp = t[15:0];
    return res;
  endfunction

  task automatic reg_write(logic [7:0] idx, logic [47:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      ntc_pkg::RegRup:   rup_ohms = val[19:0];
      ntc_pkg::RegCoefA: k_a = val;
      ntc_pkg::RegCoefB: k_b = val;
      ntc_pkg::RegCoefC: k_c = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  // send one code; with typed set the expected result is the given one, checked against the predictor
  task automatic send_code(logic [11:0] code, bit typed, reading_t fixed, int gap);
    reading_t exp_r;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.adc_code <= code;
    do @(posedge clk_i); while (!in_if.ready);
    exp_r = typed ? fixed : convert_code(code);
    if (typed && exp_r != convert_code(code)) begin
      $error("directed row code %0d disagrees with predictor", code);
      errors++;
    end
    pending_q.push_back(exp_r);
    if (exp_r.stat == ntc_pkg::StatSat) n_sat++;
    if (exp_r.stat == ntc_pkg::StatRail) n_rail++;
    n_items++;
  endtask

  task automatic send_one(logic [11:0] code);
    int gap;
    reading_t none;
    none = '{16'sd0, ntc_pkg::StatOk};
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    send_code(code, 1'b0, none, gap);
  endtask

  task automatic random_codes(int count);
    logic [11:0] code;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: code = $urandom_range(0, 1) ? 12'd0 : 12'hFFF;
        1: code = $urandom_range(1, 40);
        2: code = $urandom_range(4050, 4094);
        default: code = $urandom_range(0, 4095);
      endcase
      send_one(code);
    end
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    int waitc;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_long = 0;
      end
      waitc = ($urandom_range(0, 3) == 0 || drain_on) ? 0 : $urandom_range(0, 18);
      if (waitc != 0) begin
        out_if.ready <= 1'b0;
        repeat (waitc) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = pending_q.pop_front();
        n_results++;
        if (out_if.temperature_centi !== e.temp) begin
          $error("temperature_centi expected %0d got %0d", e.temp,
                 out_if.temperature_centi);
          errors++;
        end
        if (out_if.status !== e.stat) begin
          $error("status expected %0d got %0d", e.stat, out_if.status);
          errors++;
        end
      end
    end
  end

  typedef struct {
    logic [11:0] code;
    bit          typed;
    reading_t    res;
  } row_t;

  row_t rows[] = '{
    '{12'd0,    1'b1, '{16'sd0, ntc_pkg::StatRail}},
    '{12'hFFF,  1'b1, '{16'sd0, ntc_pkg::StatRail}},
    '{12'd2048, 1'b0, '{16'sd0, ntc_pkg::StatOk}},
    '{12'd1,    1'b0, '{16'sd0, ntc_pkg::StatOk}},
    '{12'd4094, 1'b0, '{16'sd0, ntc_pkg::StatOk}},
    '{12'd1000, 1'b0, '{16'sd0, ntc_pkg::StatOk}},
    '{12'd3000, 1'b0, '{16'sd0, ntc_pkg::StatOk}},
    '{12'hAAA,  1'b0, '{16'sd0, ntc_pkg::StatOk}},
    '{12'h555,  1'b0, '{16'sd0, ntc_pkg::StatOk}}
  };

  initial begin
    reading_t none;
    none = '{16'sd0, ntc_pkg::StatOk};
    rup_ohms = ntc_pkg::RupReset;
    k_a = ntc_pkg::CoefAReset;
    k_b = ntc_pkg::CoefBReset;
    k_c = ntc_pkg::CoefCReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_code(rows[i].code, rows[i].typed, rows[i].res, 1);
    wait_idle();

    // zero resistor gives rail status; S zero saturates; then S at its negative and positive extremes
    reg_write(ntc_pkg::RegRup, 48'd0);
    send_code(12'd2000, 1'b1, '{16'sd0, ntc_pkg::StatRail}, 1);
    wait_idle();
    reg_write(ntc_pkg::RegRup, 48'd10000);
    reg_write(ntc_pkg::RegCoefA, 48'd0);
    reg_write(ntc_pkg::RegCoefB, 48'd0);
    reg_write(ntc_pkg::RegCoefC, 48'd0);
    reg_write(8'd200, 48'hFFFF_FFFF_FFFF);
    send_code(12'd2048, 1'b1, '{16'sd32767, ntc_pkg::StatSat}, 1);
    wait_idle();
    reg_write(ntc_pkg::RegCoefA, 48'h8000_0000_0000);
    send_code(12'd2048, 1'b0, none, 1);
    wait_idle();
    reg_write(ntc_pkg::RegCoefA, 48'h7FFF_FFFF_FFFF);
    send_code(12'd5, 1'b0, none, 1);
    wait_idle();

    reg_write(ntc_pkg::RegRup, 48'd10000);
    reg_write(ntc_pkg::RegCoefA, ntc_pkg::CoefAReset);
    reg_write(ntc_pkg::RegCoefB, ntc_pkg::CoefBReset);
    reg_write(ntc_pkg::RegCoefC, ntc_pkg::CoefCReset);
    // fill the queue behind a long hold-off
    hold_long = 1;
    random_codes(40);
    random_codes(300);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: reg_write(ntc_pkg::RegRup, 48'd1);
        1: reg_write(ntc_pkg::RegRup, 48'd1000000);
        2: reg_write(ntc_pkg::RegRup, 48'($urandom_range(1, 1000000)));
        default: reg_write(ntc_pkg::RegRup, 48'd100000);
      endcase
      reg_write(ntc_pkg::RegCoefA, 48'({$urandom, $urandom} >> $urandom_range(8, 16)));
      reg_write(ntc_pkg::RegCoefB,
                ($urandom_range(0, 1) ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF)
                ^ 48'({$urandom, $urandom}));
      reg_write(ntc_pkg::RegCoefC, 48'({$urandom, $urandom}) >> $urandom_range(0, 24));
      random_codes(140);
      wait_idle();
    end
    reg_write(ntc_pkg::RegRup, 48'd10000);
    reg_write(ntc_pkg::RegCoefA, ntc_pkg::CoefAReset);
    reg_write(ntc_pkg::RegCoefB, ntc_pkg::CoefBReset);
    reg_write(ntc_pkg::RegCoefC, ntc_pkg::CoefCReset);
    drain_on = 1;
    random_codes(500);
    wait_idle();

    $display("Covered %0d codes, %0d results checked (%0d rail, %0d saturated).",
             n_items, n_results, n_rail, n_sat);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
